### hdl/bam_pkg.sv
// Shared types and constants for the bitmap allocation map.
// Holds the operation codes, memory request struct and sizing constants.
// No dependencies.
package bam_pkg;

    localparam int MAP_BYTES_DEF = 512;   // default number of bitmap rows
    localparam int INDEX_ROWS    = 512;   // rows that a 12-bit bit index can reach
    localparam int ROW_BITS      = 8;
    localparam int WORD_ROWS     = 8;     // rows packed into one memory word
    localparam int WORD_BITS     = ROW_BITS * WORD_ROWS;
    localparam int WORD_AW_MAX   = 6;     // address bits for INDEX_ROWS / WORD_ROWS words
    localparam int POS_W         = 6;     // bit position inside a memory word
    localparam int ROW_SEL_W     = 3;     // row inside a word, bit inside a row
    localparam int IDX_W         = 12;
    localparam int MODE_W        = 2;
    localparam int USED_W        = 10;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [USED_W-1:0]    USED_RESET  = 10'd512;
    localparam logic [ROW_BITS-1:0]  FULL_ROW    = 8'hff;
    localparam logic [ROW_SEL_W-1:0] ROW_POS_MAX = 3'd7;

    // register index, carried on paddr[2]
    localparam logic REG_USED_BYTES = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_TEST  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_FIND  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                   we;
        logic [WORD_AW_MAX-1:0] waddr;
        logic [WORD_BITS-1:0]   wdata;
        logic                   re;
        logic [WORD_AW_MAX-1:0] raddr;
    } t_mem_req;

endpackage

### hdl/bitmap_allocation_map.sv
// Top level of the bitmap allocation map: APB register, sequencer and bitmap store.
// Depends on bam_pkg, bam_ctrl, bam_map_mem.
//
//   channel   handshake                      payload
//   --------  -----------------------------  ------------------------------------
//   command   start, busy (take: start&!busy) i_mode, i_bit_index
//   result    o_done (one-cycle strobe)      o_bit_value, o_found, o_found_index
//   config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata (used_bytes @ 0)
//
// Test, set and clear go through a read state and then a modify/write state before the result strobe.
// Find reads one 64-bit word (8 rows) a cycle until it hits a free bit or passes the last used row.
// An out-of-range index or an empty find range returns its result strobe in the cycle after acceptance.
// Reset clears the per-word valid flags at once, so the bitmap reads as all free immediately.
// The result strobe cannot be stalled; the next command is taken once busy is low.
module bitmap_allocation_map #(
    parameter int MAP_BYTES = bam_pkg::MAP_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bam_pkg::MODE_W-1:0]        i_mode,
    input  logic [bam_pkg::IDX_W-1:0]         i_bit_index,
    output logic                              o_done,
    output logic                              o_bit_value,
    output logic                              o_found,
    output logic [bam_pkg::IDX_W-1:0]         o_found_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bam_pkg::APB_AW-1:0]        paddr,
    input  logic [bam_pkg::APB_DW-1:0]        pwdata,
    output logic [bam_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int ROWS  = (MAP_BYTES < bam_pkg::INDEX_ROWS) ? MAP_BYTES : bam_pkg::INDEX_ROWS;
    localparam int WORDS = (ROWS + bam_pkg::WORD_ROWS - 1) / bam_pkg::WORD_ROWS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(WORDS + 1);

    logic [bam_pkg::USED_W-1:0]    r_used_bytes;
    logic                          cfg_wr;
    bam_pkg::t_mem_req             mem_req;
    logic [bam_pkg::WORD_BITS-1:0] mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_bytes <= bam_pkg::USED_RESET;
        end else if (cfg_wr && (paddr[2] == bam_pkg::REG_USED_BYTES)) begin
            r_used_bytes <= pwdata[bam_pkg::USED_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bam_pkg::REG_USED_BYTES) ?
                    bam_pkg::APB_DW'(r_used_bytes) : '0;

    bam_ctrl #(
        .ROWS  (ROWS),
        .WORDS (WORDS),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_mode        (i_mode),
        .i_bit_index   (i_bit_index),
        .i_used_bytes  (r_used_bytes),
        .i_rdata       (mem_rdata),
        .o_req         (mem_req),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_bit_value   (o_bit_value),
        .o_found       (o_found),
        .o_found_index (o_found_index)
    );

    bam_map_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

### hdl/bam_zero_find.sv
// First-zero encoder over one 64-bit bitmap word, rows outside range masked.
// Depends on bam_pkg.
module bam_zero_find (
    input  logic [bam_pkg::WORD_BITS-1:0] i_word,
    input  logic [bam_pkg::WORD_ROWS-1:0] i_row_en,
    output logic                          o_hit,
    output logic [bam_pkg::POS_W-1:0]     o_pos
);

    logic [bam_pkg::WORD_ROWS-1:0] row_free;
    logic [bam_pkg::ROW_SEL_W-1:0] row_sel;
    logic [bam_pkg::ROW_SEL_W-1:0] bit_sel;
    logic [bam_pkg::ROW_BITS-1:0]  row_val;

    always_comb begin
        for (int j = 0; j < bam_pkg::WORD_ROWS; j++) begin
            row_free[j] = i_row_en[j] &&
                (i_word[j*bam_pkg::ROW_BITS +: bam_pkg::ROW_BITS] != bam_pkg::FULL_ROW);
        end
        // scan downwards so the lowest free row wins
        row_sel = '0;
        for (int j = bam_pkg::WORD_ROWS - 1; j >= 0; j--) begin
            if (row_free[j]) begin
                row_sel = bam_pkg::ROW_SEL_W'(j);
            end
        end
        row_val = i_word[row_sel*bam_pkg::ROW_BITS +: bam_pkg::ROW_BITS];
        bit_sel = bam_pkg::ROW_POS_MAX;
        for (int k = bam_pkg::ROW_BITS - 1; k >= 0; k--) begin
            if (!row_val[k]) begin
                bit_sel = bam_pkg::ROW_SEL_W'(k);
            end
        end
        o_hit = |row_free;
        o_pos = {row_sel, bit_sel};
    end

endmodule

### hdl/bam_map_mem.sv
// Bitmap store: one-read one-write synchronous memory of 64-bit words.
// Per-word valid flags make unwritten words read as zero after reset. Depends on bam_pkg.
module bam_map_mem #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bam_pkg::t_mem_req             i_req,
    output logic [bam_pkg::WORD_BITS-1:0] o_rdata
);

    logic [bam_pkg::WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]              r_valid;
    logic [bam_pkg::WORD_BITS-1:0] r_q;
    logic                          r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr[AW-1:0]] <= 1'b1;
            end
            if (i_req.re) begin
                r_q_valid <= r_valid[i_req.raddr[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_q_valid ? r_q : '0;

endmodule

### hdl/bam_ctrl.sv
// Operation sequencer: read for test, read-modify-write for set/clear, pipelined word scan for find.
// Depends on bam_pkg and bam_zero_find; drives bam_map_mem through a t_mem_req.
module bam_ctrl #(
    parameter int ROWS  = 512,
    parameter int WORDS = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bam_pkg::MODE_W-1:0]    i_mode,
    input  logic [bam_pkg::IDX_W-1:0]     i_bit_index,
    input  logic [bam_pkg::USED_W-1:0]    i_used_bytes,
    input  logic [bam_pkg::WORD_BITS-1:0] i_rdata,
    output bam_pkg::t_mem_req             o_req,
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_bit_value,
    output logic                          o_found,
    output logic [bam_pkg::IDX_W-1:0]     o_found_index
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_MODIFY = 4'b0100,
        ST_SCAN   = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    bam_pkg::t_mode                r_mode, n_mode;
    logic [bam_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [CW-1:0]                 r_nw, n_nw;
    logic [bam_pkg::ROW_SEL_W-1:0] r_tail, n_tail;
    logic [CW-1:0]                 r_issue, n_issue;
    logic                          r_chk_vld, n_chk_vld;
    logic [AW-1:0]                 r_chk_word, n_chk_word;
    logic                          r_done, n_done;
    logic                          r_bit_value, n_bit_value;
    logic                          r_found, n_found;
    logic [bam_pkg::IDX_W-1:0]     r_found_index, n_found_index;

    logic [bam_pkg::USED_W-1:0]    lim;
    logic [bam_pkg::USED_W:0]      nw_full;
    logic                          in_store;
    logic                          last_word;
    logic [bam_pkg::ROW_SEL_W:0]   tail_rows;
    logic [bam_pkg::WORD_ROWS-1:0] row_en;
    logic                          hit;
    logic [bam_pkg::POS_W-1:0]     hit_pos;
    logic [bam_pkg::WORD_BITS-1:0] bit_mask;

    // scanned rows saturate at the stored/addressable row count
    assign lim = (i_used_bytes > bam_pkg::USED_W'(ROWS)) ? bam_pkg::USED_W'(ROWS)
                                                          : i_used_bytes;
    assign nw_full  = ({1'b0, lim} + (bam_pkg::USED_W + 1)'(bam_pkg::ROW_POS_MAX)) >> 3;
    assign in_store = ({1'b0, i_bit_index[bam_pkg::IDX_W-1:3]} < bam_pkg::USED_W'(ROWS));

    assign last_word = (CW'(r_chk_word) == (r_nw - CW'(1)));
    assign tail_rows = (r_tail == '0) ? (bam_pkg::ROW_SEL_W + 1)'(bam_pkg::WORD_ROWS)
                                      : {1'b0, r_tail};
    assign bit_mask  = bam_pkg::WORD_BITS'(1) << r_idx[bam_pkg::POS_W-1:0];

    always_comb begin
        for (int j = 0; j < bam_pkg::WORD_ROWS; j++) begin
            row_en[j] = !last_word || ((bam_pkg::ROW_SEL_W + 1)'(j) < tail_rows);
        end
    end

    bam_zero_find u_zero_find (
        .i_word   (i_rdata),
        .i_row_en (row_en),
        .o_hit    (hit),
        .o_pos    (hit_pos)
    );

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_idx         = r_idx;
        n_nw          = r_nw;
        n_tail        = r_tail;
        n_issue       = r_issue;
        n_chk_vld     = 1'b0;
        n_chk_word    = r_chk_word;
        n_done        = 1'b0;
        n_bit_value   = 1'b0;
        n_found       = 1'b0;
        n_found_index = '0;
        o_req         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_mode  = bam_pkg::t_mode'(i_mode);
                    n_idx   = i_bit_index;
                    n_nw    = CW'(nw_full);
                    n_tail  = lim[bam_pkg::ROW_SEL_W-1:0];
                    n_issue = '0;
                    if (bam_pkg::t_mode'(i_mode) == bam_pkg::MODE_FIND) begin
                        if (nw_full == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else if (in_store) begin
                        n_state = ST_READ;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_req.re    = 1'b1;
                o_req.raddr = bam_pkg::WORD_AW_MAX'(r_idx[bam_pkg::POS_W +: AW]);
                n_state     = ST_MODIFY;
            end
            ST_MODIFY: begin
                n_done      = 1'b1;
                n_state     = ST_IDLE;
                o_req.waddr = bam_pkg::WORD_AW_MAX'(r_idx[bam_pkg::POS_W +: AW]);
                case (r_mode)
                    bam_pkg::MODE_TEST: begin
                        n_bit_value = i_rdata[r_idx[bam_pkg::POS_W-1:0]];
                    end
                    bam_pkg::MODE_SET: begin
                        o_req.we    = 1'b1;
                        o_req.wdata = i_rdata | bit_mask;
                    end
                    bam_pkg::MODE_CLEAR: begin
                        o_req.we    = 1'b1;
                        o_req.wdata = i_rdata & ~bit_mask;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // issue one word read a cycle; check the word returned from the previous read
                if (r_issue < r_nw) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = bam_pkg::WORD_AW_MAX'(r_issue[AW-1:0]);
                    n_issue     = r_issue + CW'(1);
                    n_chk_vld   = 1'b1;
                    n_chk_word  = r_issue[AW-1:0];
                end
                if (r_chk_vld) begin
                    if (hit) begin
                        n_done        = 1'b1;
                        n_found       = 1'b1;
                        n_found_index = (bam_pkg::IDX_W'(r_chk_word) << bam_pkg::POS_W) |
                                        bam_pkg::IDX_W'(hit_pos);
                        n_chk_vld     = 1'b0;
                        n_state       = ST_IDLE;
                    end else if (last_word) begin
                        n_done    = 1'b1;
                        n_chk_vld = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_idx         <= n_idx;
        r_nw          <= n_nw;
        r_tail        <= n_tail;
        r_issue       <= n_issue;
        r_chk_word    <= n_chk_word;
        r_bit_value   <= n_bit_value;
        r_found       <= n_found;
        r_found_index <= n_found_index;
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_bit_value   = r_bit_value;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

endmodule

### hdl/bam_checker.sv
// Port-level checks for the bitmap allocation map, bound to the top level.
// Depends on bam_pkg for field widths.
module bam_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic                          o_bit_value,
    input logic                          o_found,
    input logic [bam_pkg::IDX_W-1:0]     o_found_index
);

    // leave reset idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("busy or result strobe after reset");

    // an accepted transaction either goes busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither busy nor answered");

    // drop busy only together with the result
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    // a result follows work or an acceptance
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result strobe with no transaction");

    // found results carry no stored bit; not-found carries a zero index
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_found || (o_found_index == '0)) && !(o_found && o_bit_value)))
        else $error("result fields inconsistent with the found bit");

endmodule

bind bitmap_allocation_map bam_checker u_bam_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_bit_value   (o_bit_value),
    .o_found       (o_found),
    .o_found_index (o_found_index)
);
